// ===== rtl/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types for the box versus frustum culling core.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int NUM_PLANES      = 6;
  localparam int PLANE_W         = 64;
  localparam int NORM_W          = 16;
  localparam int DIST_W          = 16;
  localparam int DIST_SHIFT      = 14;
  localparam int CNT_OUT_W       = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int APB_ADDR_W      = 6;
  localparam int APB_DATA_W      = 64;
  localparam int REG_IDX_W       = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } afc_reg_e;

  // flags that travel with an item down the plane chain
  typedef struct packed {
    logic frame_start;
    logic object_visible;
    logic has_bounds;
    logic pass;
  } afc_flags_t;

endpackage

// ===== rtl/afc_if.sv =====
// ----------------------------------------------------------------------------
// afc_in_if / afc_out_if
// Valid/ready channels carrying object items in and cull results out.
// ----------------------------------------------------------------------------
interface afc_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          frame_start;
  logic                          object_visible;
  logic                          has_bounds;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] min_z;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  logic signed [COORD_WIDTH-1:0] max_z;

  modport source (
    output valid, frame_start, object_visible, has_bounds,
           min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, frame_start, object_visible, has_bounds,
           min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

interface afc_out_if;
  logic        valid;
  logic        ready;
  logic        in_frustum;
  logic [15:0] total_count;
  logic [15:0] hidden_count;
  logic [15:0] bypass_count;
  logic [15:0] tested_count;
  logic [15:0] passed_count;
  logic [15:0] culled_count;
  logic [15:0] main_visible_count;

  modport source (
    output valid, in_frustum, total_count, hidden_count, bypass_count,
           tested_count, passed_count, culled_count, main_visible_count,
    input  ready
  );
  modport sink (
    input  valid, in_frustum, total_count, hidden_count, bypass_count,
           tested_count, passed_count, culled_count, main_visible_count,
    output ready
  );
endinterface

// ===== rtl/afc_plane_cell.sv =====
// ----------------------------------------------------------------------------
// afc_plane_cell
// One plane of the frustum test: positive-vertex products, then the signed
// sum against the plane distance, two register stages with valid/ready.
// ----------------------------------------------------------------------------
module afc_plane_cell #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [afc_pkg::PLANE_W-1:0]    plane_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  afc_pkg::afc_flags_t            flags_i,
  input  logic signed [COORD_WIDTH-1:0]  lo_i [3],
  input  logic signed [COORD_WIDTH-1:0]  hi_i [3],
  output logic                           valid_o,
  input  logic                           ready_i,
  output afc_pkg::afc_flags_t            flags_o,
  output logic signed [COORD_WIDTH-1:0]  lo_o [3],
  output logic signed [COORD_WIDTH-1:0]  hi_o [3]
);
  import afc_pkg::*;

  localparam int PROD_W = NORM_W + COORD_WIDTH;
  localparam int ACC_W  = (COORD_WIDTH + 18 > 32) ? COORD_WIDTH + 18 : 32;

  logic signed [NORM_W-1:0]      norm [3];
  logic signed [DIST_W-1:0]      plane_dist;
  logic signed [COORD_WIDTH-1:0] vtx  [3];
  logic signed [PROD_W-1:0]      prod_d [3];
  logic signed [PROD_W-1:0]      prod_q [3];
  logic signed [ACC_W-1:0]       acc;

  logic                          s1_valid_q, s2_valid_q;
  logic                          s1_ready, s2_ready;
  afc_flags_t                    s1_flags_q, s2_flags_q;
  afc_flags_t                    s2_flags_d;
  logic signed [COORD_WIDTH-1:0] s1_lo_q [3];
  logic signed [COORD_WIDTH-1:0] s1_hi_q [3];
  logic signed [COORD_WIDTH-1:0] s2_lo_q [3];
  logic signed [COORD_WIDTH-1:0] s2_hi_q [3];

  assign norm[0]    = plane_i[63:48];
  assign norm[1]    = plane_i[47:32];
  assign norm[2]    = plane_i[31:16];
  assign plane_dist = plane_i[15:0];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vtx[a]    = norm[a][NORM_W-1] ? lo_i[a] : hi_i[a];
      prod_d[a] = norm[a] * vtx[a];
    end
  end

  assign acc = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2])
             + (ACC_W'(plane_dist) <<< DIST_SHIFT);

  always_comb begin
    s2_flags_d      = s1_flags_q;
    s2_flags_d.pass = s1_flags_q.pass && !acc[ACC_W-1];
  end

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_flags_q <= flags_i;
      for (int a = 0; a < 3; a++) begin
        prod_q[a]  <= prod_d[a];
        s1_lo_q[a] <= lo_i[a];
        s1_hi_q[a] <= hi_i[a];
      end
    end
    if (s2_ready && s1_valid_q) begin
      s2_flags_q <= s2_flags_d;
      for (int a = 0; a < 3; a++) begin
        s2_lo_q[a] <= s1_lo_q[a];
        s2_hi_q[a] <= s1_hi_q[a];
      end
    end
  end

  assign valid_o = s2_valid_q;
  assign flags_o = s2_flags_q;
  assign lo_o    = s2_lo_q;
  assign hi_o    = s2_hi_q;

endmodule

// ===== rtl/afc_stats.sv =====
// ----------------------------------------------------------------------------
// afc_stats
// Per-frame saturating counters and the registered result item.
// ----------------------------------------------------------------------------
module afc_stats #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  afc_pkg::afc_flags_t flags_i,
  afc_out_if.source           out_ch
);
  import afc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [COUNT_WIDTH-1:0] bump(
    input logic [COUNT_WIDTH-1:0] c,
    input logic                   en
  );
    return (en && c != CNT_MAX) ? c + 1'b1 : c;
  endfunction

  logic                   out_valid_q;
  logic                   take;
  logic                   is_hidden, is_bypass, is_tested, is_passed, is_culled;
  logic [COUNT_WIDTH-1:0] total_q, hidden_q, bypass_q, tested_q;
  logic [COUNT_WIDTH-1:0] passed_q, culled_q, main_q;
  logic [COUNT_WIDTH-1:0] total_d, hidden_d, bypass_d, tested_d;
  logic [COUNT_WIDTH-1:0] passed_d, culled_d, main_d;
  logic                   in_frustum_q;

  assign ready_o = !out_valid_q || out_ch.ready;
  assign take    = ready_o && valid_i;

  assign is_hidden = !flags_i.object_visible;
  assign is_bypass = flags_i.object_visible && !flags_i.has_bounds;
  assign is_tested = flags_i.object_visible && flags_i.has_bounds;
  assign is_passed = is_tested && flags_i.pass;
  assign is_culled = is_tested && !flags_i.pass;

  always_comb begin
    total_d  = flags_i.frame_start ? '0 : total_q;
    hidden_d = flags_i.frame_start ? '0 : hidden_q;
    bypass_d = flags_i.frame_start ? '0 : bypass_q;
    tested_d = flags_i.frame_start ? '0 : tested_q;
    passed_d = flags_i.frame_start ? '0 : passed_q;
    culled_d = flags_i.frame_start ? '0 : culled_q;
    main_d   = flags_i.frame_start ? '0 : main_q;
    total_d  = bump(total_d, 1'b1);
    hidden_d = bump(hidden_d, is_hidden);
    bypass_d = bump(bypass_d, is_bypass);
    tested_d = bump(tested_d, is_tested);
    passed_d = bump(passed_d, is_passed);
    culled_d = bump(culled_d, is_culled);
    main_d   = bump(main_d, is_bypass || is_passed);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
      hidden_q    <= '0;
      bypass_q    <= '0;
      tested_q    <= '0;
      passed_q    <= '0;
      culled_q    <= '0;
      main_q      <= '0;
    end else begin
      if (ready_o) out_valid_q <= valid_i;
      if (take) begin
        total_q  <= total_d;
        hidden_q <= hidden_d;
        bypass_q <= bypass_d;
        tested_q <= tested_d;
        passed_q <= passed_d;
        culled_q <= culled_d;
        main_q   <= main_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_frustum_q <= !is_culled;
  end

  assign out_ch.valid              = out_valid_q;
  assign out_ch.in_frustum         = in_frustum_q;
  assign out_ch.total_count        = CNT_OUT_W'(total_q);
  assign out_ch.hidden_count       = CNT_OUT_W'(hidden_q);
  assign out_ch.bypass_count       = CNT_OUT_W'(bypass_q);
  assign out_ch.tested_count       = CNT_OUT_W'(tested_q);
  assign out_ch.passed_count       = CNT_OUT_W'(passed_q);
  assign out_ch.culled_count       = CNT_OUT_W'(culled_q);
  assign out_ch.main_visible_count = CNT_OUT_W'(main_q);

endmodule

// ===== rtl/aabb_frustum_cull_core.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core
// Six-plane positive-vertex frustum test of axis-aligned boxes, with
// per-frame saturating statistics and an APB plane register file.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    flags, box min/max xyz
//  out_ch    out  valid / ready    in_frustum, seven counters
//  apb       in   psel / penable   six 64-bit plane registers
//
//  One item per cycle while out_ch is ready; two register stages per plane
//  cell, six cells, then the counter/output register.
//  Each stage takes a new item when it is empty or its successor moves, so
//  a stall at out_ch fills the chain before in_ch.ready drops.
//  Reset clears the planes (every box passes) and all counters.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core #(
  parameter int COUNT_WIDTH = afc_pkg::COUNT_WIDTH_DEF,
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  afc_in_if.sink                          in_ch,
  afc_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [afc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [afc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [afc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import afc_pkg::*;

  logic [PLANE_W-1:0]            plane_q [NUM_PLANES];
  logic [REG_IDX_W-1:0]          reg_idx;
  logic                          cfg_wr;

  logic                          cell_v   [NUM_PLANES+1];
  logic                          cell_rdy [NUM_PLANES+1];
  afc_flags_t                    cell_flags [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0] cell_lo [NUM_PLANES+1][3];
  logic signed [COORD_WIDTH-1:0] cell_hi [NUM_PLANES+1][3];

  // register file
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PLANES; p++) plane_q[p] <= '0;
    end else if (cfg_wr && reg_idx <= REG_PLANE_FAR) begin
      plane_q[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx <= REG_PLANE_FAR) prdata = plane_q[reg_idx];
  end

  // chain entry
  assign cell_v[0]                  = in_ch.valid;
  assign in_ch.ready                = cell_rdy[0];
  assign cell_flags[0].frame_start    = in_ch.frame_start;
  assign cell_flags[0].object_visible = in_ch.object_visible;
  assign cell_flags[0].has_bounds     = in_ch.has_bounds;
  assign cell_flags[0].pass           = 1'b1;
  assign cell_lo[0][0] = in_ch.min_x;
  assign cell_lo[0][1] = in_ch.min_y;
  assign cell_lo[0][2] = in_ch.min_z;
  assign cell_hi[0][0] = in_ch.max_x;
  assign cell_hi[0][1] = in_ch.max_y;
  assign cell_hi[0][2] = in_ch.max_z;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    afc_plane_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .plane_i (plane_q[k]),
      .valid_i (cell_v[k]),
      .ready_o (cell_rdy[k]),
      .flags_i (cell_flags[k]),
      .lo_i    (cell_lo[k]),
      .hi_i    (cell_hi[k]),
      .valid_o (cell_v[k+1]),
      .ready_i (cell_rdy[k+1]),
      .flags_o (cell_flags[k+1]),
      .lo_o    (cell_lo[k+1]),
      .hi_o    (cell_hi[k+1])
    );
  end

  afc_stats #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cell_v[NUM_PLANES]),
    .ready_o (cell_rdy[NUM_PLANES]),
    .flags_i (cell_flags[NUM_PLANES]),
    .out_ch  (out_ch)
  );

  // checks
  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && reg_idx > REG_PLANE_FAR |=> $stable(plane_q[0]) && $stable(plane_q[5]))
    else $error("write beyond register list changed a plane");

  a_culled_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_v[NUM_PLANES] && cell_rdy[NUM_PLANES] && !cell_flags[NUM_PLANES].pass &&
    cell_flags[NUM_PLANES].object_visible && cell_flags[NUM_PLANES].has_bounds
    |=> out_ch.valid && !out_ch.in_frustum)
    else $error("failed box not reported as culled");

  a_hidden_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_v[NUM_PLANES] && cell_rdy[NUM_PLANES] && !cell_flags[NUM_PLANES].object_visible
    |=> out_ch.valid && out_ch.in_frustum)
    else $error("hidden object reported as culled");

endmodule

// ===== bench/aabb_frustum_cull_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_core_test
// Self-checking bench for the frustum culling core. A directed table runs
// first, with zero planes after reset and then with extreme planes. Random
// phases follow, each with a fresh plane set; five have random flow control
// on both channels and one a long output stall. Results are checked item by
// item against the table's expected values or else a local predictor.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_core_test;
  import afc_pkg::*;

  localparam int unsigned RUN_LIMIT = 1_500_000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  localparam logic [15:0] CMIN    = 16'h8000;
  localparam logic [15:0] CMAX    = 16'h7FFF;
  localparam logic [15:0] CNT_TOP = 16'hFFFF;

  // register slots written: the plane file and the unmapped slots past it, where writes must be dropped
  localparam int REG_SLOTS = 8;

  typedef struct packed {
    logic [15:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  typedef struct packed {
    logic frame_start;
    logic object_visible;
    logic has_bounds;
    box_t box;
  } obj_t;

  typedef struct packed {
    logic        in_frustum;
    logic [15:0] total_count;
    logic [15:0] hidden_count;
    logic [15:0] bypass_count;
    logic [15:0] tested_count;
    logic [15:0] passed_count;
    logic [15:0] culled_count;
    logic [15:0] main_visible_count;
  } verdict_t;

  typedef struct packed {
    logic     reload;
    obj_t     obj;
    logic     typed;
    verdict_t want;
  } row_t;

  localparam logic [63:0] EXTREME_PLANES [NUM_PLANES] = '{
    64'h8000_0000_0000_7FFF,
    64'h7FFF_0000_0000_7FFF,
    64'h0000_8000_8000_8000,
    64'h0000_7FFF_7FFF_0000,
    64'h0000_0000_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  localparam row_t DIRECTED [17] = '{
    // zero planes after reset: every box passes
    '{1'b0, '{1'b1, 1'b1, 1'b1, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}},
      1'b1, '{1'b1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1}},
    '{1'b0, '{1'b0, 1'b0, 1'b1, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
      1'b1, '{1'b1, 16'd2, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0, 16'd1}},
    '{1'b0, '{1'b0, 1'b1, 1'b0, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
      1'b1, '{1'b1, 16'd3, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd2}},
    // inverted box
    '{1'b0, '{1'b0, 1'b1, 1'b1, '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}},
      1'b1, '{1'b1, 16'd4, 16'd1, 16'd1, 16'd2, 16'd2, 16'd0, 16'd3}},
    '{1'b0, '{1'b1, 1'b0, 1'b0, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}},
      1'b1, '{1'b1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
    '{1'b0, '{1'b1, 1'b1, 1'b0, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
      1'b1, '{1'b1, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1}},
    // extreme planes from here on
    '{1'b1, '{1'b1, 1'b1, 1'b1, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1, '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1,
      '{16'hFF00, 16'hFF00, 16'hFF00, 16'h0100, 16'h0100, 16'h0100}}, 1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1,
      '{16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF}}, 1'b0, '0},
    '{1'b0, '{1'b0, 1'b0, 1'b1, '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}},
      1'b0, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}},
      1'b0, '0},
    '{1'b0, '{1'b1, 1'b1, 1'b1, '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}},
      1'b0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  afc_in_if #(.COORD_WIDTH(COORD_WIDTH_DEF)) obj_ch ();
  afc_out_if                                 res_ch ();

  aabb_frustum_cull_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (obj_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0] plane_q    [NUM_PLANES];
  logic [63:0] plane_plan [NUM_PLANES];
  verdict_t    frame_tally;
  verdict_t    verdicts_due [$];
  int          send_gap_pct;
  int          take_gap_pct;
  int          out_hold_left;
  int          mismatch_cnt;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---- predictor ----

  function automatic logic box_in_frustum(box_t b);
    longint acc;
    longint nrm;
    logic [63:0] pl;
    for (int p = 0; p < NUM_PLANES; p++) begin
      pl  = plane_q[p];
      acc = longint'($signed(pl[15:0])) <<< DIST_SHIFT;
      for (int a = 0; a < 3; a++) begin
        nrm = longint'($signed(pl[63-16*a -: 16]));
        if (nrm >= 0)
          acc += nrm * longint'($signed(b[47-16*a -: 16]));
        else
          acc += nrm * longint'($signed(b[95-16*a -: 16]));
      end
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] c);
    return (c == CNT_TOP) ? c : c + 16'd1;
  endfunction

  function automatic verdict_t predict_verdict(obj_t o);
    if (o.frame_start) frame_tally = '0;
    frame_tally.in_frustum  = 1'b1;
    frame_tally.total_count = sat_inc(frame_tally.total_count);
    if (!o.object_visible) begin
      frame_tally.hidden_count = sat_inc(frame_tally.hidden_count);
    end else if (!o.has_bounds) begin
      frame_tally.bypass_count       = sat_inc(frame_tally.bypass_count);
      frame_tally.main_visible_count = sat_inc(frame_tally.main_visible_count);
    end else begin
      frame_tally.tested_count = sat_inc(frame_tally.tested_count);
      if (box_in_frustum(o.box)) begin
        frame_tally.passed_count       = sat_inc(frame_tally.passed_count);
        frame_tally.main_visible_count = sat_inc(frame_tally.main_visible_count);
      end else begin
        frame_tally.in_frustum   = 1'b0;
        frame_tally.culled_count = sat_inc(frame_tally.culled_count);
      end
    end
    return frame_tally;
  endfunction

  // ---- random content ----

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(3))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [63:0] pick_plane();
    logic [63:0] v;
    int unsigned k;
    k = $urandom_range(9);
    v = {$urandom, $urandom};
    if (k < 3) begin
      v = '0;
    end else if (k == 3) begin
      v = '1;
    end else if (k < 6) begin
      for (int c = 0; c < 4; c++) v[16*c +: 16] = pick_edge();
    end else if (k < 9) begin
      v[15] = 1'b0;   // non-negative distance, more boxes pass
    end
    return v;
  endfunction

  function automatic obj_t pick_object();
    obj_t o;
    int   mid;
    int   half;
    o.frame_start    = ($urandom_range(99) < 4);
    o.object_visible = ($urandom_range(99) < 85);
    o.has_bounds     = ($urandom_range(99) < 85);
    case ($urandom_range(9))
      0, 1: begin
        o.box = {$urandom, $urandom, $urandom};
      end
      2: begin
        for (int f = 0; f < 6; f++) o.box[16*f +: 16] = pick_edge();
      end
      default: begin
        for (int a = 0; a < 3; a++) begin
          mid  = int'($urandom_range(8191)) - 4096;
          half = int'($urandom_range(1024));
          o.box[95-16*a -: 16] = 16'(mid - half);
          o.box[47-16*a -: 16] = 16'(mid + half);
        end
      end
    endcase
    return o;
  endfunction

  // ---- drivers ----

  task automatic offer(input obj_t o, input logic typed, input verdict_t want);
    verdict_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      obj_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    obj_ch.valid          <= 1'b1;
    obj_ch.frame_start    <= o.frame_start;
    obj_ch.object_visible <= o.object_visible;
    obj_ch.has_bounds     <= o.has_bounds;
    obj_ch.min_x          <= o.box.min_x;
    obj_ch.min_y          <= o.box.min_y;
    obj_ch.min_z          <= o.box.min_z;
    obj_ch.max_x          <= o.box.max_x;
    obj_ch.max_y          <= o.box.max_y;
    obj_ch.max_z          <= o.box.max_z;
    @(posedge clk_i);
    while (obj_ch.ready !== 1'b1) @(posedge clk_i);
    pred = predict_verdict(o);
    if (typed) pred = want;
    verdicts_due = {verdicts_due, pred};
  endtask

  task automatic drain();
    obj_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  // writes plane_plan into the plane file, plus junk into the unmapped slots
  task automatic load_planes();
    logic [63:0] val;
    drain();
    for (int idx = 0; idx < REG_SLOTS; idx++) begin
      val = (idx < NUM_PLANES) ? plane_plan[idx] : {$urandom, $urandom};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_W'(idx * 8);
      pwdata  <= val;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (pready !== 1'b1) @(posedge clk_i);
      if (idx < NUM_PLANES) plane_q[idx] = val;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---- result checking ----

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      if (mismatch_cnt < MAX_REPORTS)
        $display("%s mismatch: expected %h, got %h", what, want, got);
      mismatch_cnt++;
    end
  endtask

  initial begin : take_results
    verdict_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (verdicts_due.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("result item with nothing expected");
          mismatch_cnt++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("in_frustum", 16'(want.in_frustum), 16'(res_ch.in_frustum));
          check_field("total_count", want.total_count, res_ch.total_count);
          check_field("hidden_count", want.hidden_count, res_ch.hidden_count);
          check_field("bypass_count", want.bypass_count, res_ch.bypass_count);
          check_field("tested_count", want.tested_count, res_ch.tested_count);
          check_field("passed_count", want.passed_count, res_ch.passed_count);
          check_field("culled_count", want.culled_count, res_ch.culled_count);
          check_field("main_visible_count", want.main_visible_count,
                      res_ch.main_visible_count);
        end
      end
      if (out_hold_left > 0) begin
        res_ch.ready <= 1'b0;
        out_hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---- stimulus ----

  initial begin : stimulus
    obj_t o;
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    obj_ch.valid          <= 1'b0;
    obj_ch.frame_start    <= 1'b0;
    obj_ch.object_visible <= 1'b0;
    obj_ch.has_bounds     <= 1'b0;
    obj_ch.min_x          <= '0;
    obj_ch.min_y          <= '0;
    obj_ch.min_z          <= '0;
    obj_ch.max_x          <= '0;
    obj_ch.max_y          <= '0;
    obj_ch.max_z          <= '0;
    frame_tally   = '0;
    mismatch_cnt  = 0;
    out_hold_left = 0;
    send_gap_pct  = 30;
    take_gap_pct  = 63;
    foreach (plane_q[p]) plane_q[p] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].reload) begin
        plane_plan = EXTREME_PLANES;
        load_planes();
      end
      offer(DIRECTED[i].obj, DIRECTED[i].typed, DIRECTED[i].want);
    end

    send_gap_pct = 30;
    take_gap_pct = 63;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        send_gap_pct = 63;
        take_gap_pct = 30;
      end else if (ph == 5) begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end
      foreach (plane_plan[p]) plane_plan[p] = (ph == 0) ? '1 : pick_plane();
      load_planes();
      // long output stall while items keep coming: fills the chain
      if (ph == 5) out_hold_left = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        o = pick_object();
        if (n == 0) o.frame_start = 1'b1;
        offer(o, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/afc_pkg.sv
rtl/afc_if.sv
rtl/afc_plane_cell.sv
rtl/afc_stats.sv
rtl/aabb_frustum_cull_core.sv
bench/aabb_frustum_cull_core_test.sv
